// ----- rtl/core/pbft_pkg.sv -----
// Package of the pulse-burst frame transmitter: widths, reset values,
// register and command codes, and the queue item and result types.
// Depends on nothing; every other file of the block imports it.
package pbft_pkg;

  localparam int unsigned WordW     = 9;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned TickW     = 10;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned BitIdxW   = 4;
  localparam int unsigned MaxWords  = 32;
  localparam int unsigned QueueDepth = 2;

  localparam logic [TickW-1:0]   StartTicksRst = TickW'(120);
  localparam logic [TickW-1:0]   OneTicksRst   = TickW'(24);
  localparam logic [TickW-1:0]   ZeroTicksRst  = TickW'(60);
  localparam logic [TickW-1:0]   PauseTicksRst = TickW'(30);
  localparam logic [BitIdxW-1:0] LastBitIdx    = BitIdxW'(WordW - 1);

  typedef enum logic [CfgIdxW-1:0] {
    CfgStartTicks = 3'd0,
    CfgOneTicks   = 3'd1,
    CfgZeroTicks  = 3'd2,
    CfgPauseTicks = 3'd3
  } cfg_idx_e;

  typedef enum logic {
    CmdLoad = 1'b0,
    CmdTick = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e             cmd;
    logic [WordW-1:0] word;
    logic             last;
  } pbft_item_t;

  typedef struct packed {
    logic carrier_on;
    logic driver_on;
    logic busy_res;
    logic load_refused;
  } pbft_result_t;

endpackage

// ----- rtl/core/pulse_burst_frame_transmitter.sv -----
// Top level of the pulse-burst frame transmitter: front end, item queue
// and sequencer. Imports pbft_pkg; instantiates pbft_front, pbft_fifo
// and pbft_back.
//
//   channel  signals                                     direction
//   input    in_valid_i in_ready_o command_i data_byte_i last_byte_i   in
//   result   out_valid_o out_ready_i carrier_on_o driver_on_o
//            busy_res_o load_refused_o                   out
//   config   cfg_we_i cfg_idx_i cfg_wdata_i              in, no wait
//
// One input transfer per cycle is taken while the two-entry queue has room.
// The sequencer retires one queued item per cycle while the result is free or taken
// and loads its result at the same edge; each transfer is registered in the queue first.
// A stalled result stalls the sequencer, the queue fills, then in_ready_o falls.
// Reset is asynchronous and active low and restores the register defaults.
module pulse_burst_frame_transmitter import pbft_pkg::*; #(
  parameter int unsigned MAX_WORDS = MaxWords
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [TickW-1:0]   cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               command_i,
  input  logic [ByteW-1:0]   data_byte_i,
  input  logic               last_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               carrier_on_o,
  output logic               driver_on_o,
  output logic               busy_res_o,
  output logic               load_refused_o
);

  pbft_item_t   front_item;
  pbft_item_t   queue_item;
  pbft_result_t res;
  logic         queue_full;
  logic         queue_empty;
  logic         queue_pop;

  assign in_ready_o = ~queue_full;

  pbft_front u_front (
    .command_i   (command_i),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .item_o      (front_item)
  );

  pbft_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_valid_i),
    .item_i  (front_item),
    .full_o  (queue_full),
    .pop_i   (queue_pop),
    .empty_o (queue_empty),
    .item_o  (queue_item)
  );

  pbft_back #(
    .MAX_WORDS (MAX_WORDS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_empty_i (queue_empty),
    .item_i       (queue_item),
    .item_pop_o   (queue_pop),
    .res_valid_o  (out_valid_o),
    .res_ready_i  (out_ready_i),
    .res_o        (res)
  );

  assign carrier_on_o   = res.carrier_on;
  assign driver_on_o    = res.driver_on;
  assign busy_res_o     = res.busy_res;
  assign load_refused_o = res.load_refused;

endmodule

// ----- rtl/core/pbft_front.sv -----
// Front end of the transmitter: classifies each accepted input transfer
// and builds the nine-bit word with its parity bit. Imports pbft_pkg.
module pbft_front import pbft_pkg::*; (
  input  logic             command_i,
  input  logic [ByteW-1:0] data_byte_i,
  input  logic             last_byte_i,
  output pbft_item_t       item_o
);

  logic parity;

  assign parity = ^data_byte_i;

  always_comb begin
    item_o.cmd  = (command_i == 1'b1) ? CmdTick : CmdLoad;
    item_o.word = {parity, data_byte_i};
    item_o.last = last_byte_i & ~command_i;
  end

endmodule

// ----- rtl/core/pbft_fifo.sv -----
// Short queue between the front end and the sequencer of the transmitter.
// Holds classified items; imports pbft_pkg for the item type and depth.
module pbft_fifo import pbft_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  pbft_item_t item_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       empty_o,
  output pbft_item_t item_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  pbft_item_t            slot_q [QueueDepth];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign item_o  = slot_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(QueueDepth))
    else $error("queue count beyond depth");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == CntW'(QueueDepth)) |-> wr_ptr_q == rd_ptr_q)
    else $error("queue pointers disagree with count");
  a_pop_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_pop && !do_push) |=> cnt_q == $past(cnt_q) - CntW'(1))
    else $error("pop did not lower count");
`endif

endmodule

// ----- rtl/core/pbft_back.sv -----
// Sequencer of the transmitter: executes loads and ticks from the queue,
// owns the word store, the tick registers and the result register.
// Imports pbft_pkg for widths, codes and the item and result types.
module pbft_back import pbft_pkg::*; #(
  parameter int unsigned MAX_WORDS = MaxWords
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [TickW-1:0]   cfg_wdata_i,
  input  logic               item_empty_i,
  input  pbft_item_t         item_i,
  output logic               item_pop_o,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output pbft_result_t       res_o
);

  localparam int unsigned AddrW = $clog2(MAX_WORDS);
  localparam int unsigned CntW  = $clog2(MAX_WORDS + 1);

  logic [WordW-1:0]   store_q [MAX_WORDS];
  logic [WordW-1:0]   rd_word_q;
  logic [AddrW-1:0]   rd_addr;

  logic [TickW-1:0]   start_ticks_q, one_ticks_q, zero_ticks_q, pause_ticks_q;
  logic [CntW-1:0]    word_cnt_q, word_cnt_d;
  logic [CntW-1:0]    word_idx_q, word_idx_d;
  logic [BitIdxW-1:0] bit_idx_q, bit_idx_d;
  logic [TickW-1:0]   tick_q, tick_d;
  logic               burst_q, burst_d;
  logic               start_done_q, start_done_d;
  logic               sending_q, sending_d;
  logic               refused;
  logic               wr_en;
  logic               step;
  logic               res_valid_q;
  pbft_result_t       res_q;

  assign step        = ~item_empty_i & (~res_valid_q | res_ready_i);
  assign item_pop_o  = step;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;
  assign rd_addr     = (word_idx_q < CntW'(MAX_WORDS)) ? word_idx_q[AddrW-1:0] : '0;

  always_comb begin
    word_cnt_d   = word_cnt_q;
    word_idx_d   = word_idx_q;
    bit_idx_d    = bit_idx_q;
    tick_d       = tick_q;
    burst_d      = burst_q;
    start_done_d = start_done_q;
    sending_d    = sending_q;
    refused      = 1'b0;
    wr_en        = 1'b0;
    if (step) begin
      if (item_i.cmd == CmdTick) begin
        if (sending_q) begin
          if (tick_q != '0) begin
            tick_d = tick_q - TickW'(1);
          end else if (word_idx_q >= word_cnt_q) begin
            word_idx_d   = '0;
            bit_idx_d    = '0;
            tick_d       = '0;
            start_done_d = 1'b0;
            burst_d      = 1'b0;
            sending_d    = 1'b0;
            word_cnt_d   = '0;
          end else if (burst_q) begin
            burst_d = 1'b0;
            tick_d  = pause_ticks_q;
          end else if (!start_done_q) begin
            tick_d       = start_ticks_q;
            start_done_d = 1'b1;
            burst_d      = 1'b1;
          end else begin
            tick_d  = rd_word_q[bit_idx_q] ? one_ticks_q : zero_ticks_q;
            burst_d = 1'b1;
            if (bit_idx_q == LastBitIdx) begin
              bit_idx_d  = '0;
              word_idx_d = word_idx_q + CntW'(1);
            end else begin
              bit_idx_d = bit_idx_q + BitIdxW'(1);
            end
          end
        end
      end else begin
        if (sending_q) begin
          refused = 1'b1;
        end else if (word_cnt_q >= CntW'(MAX_WORDS)) begin
          refused    = 1'b1;
          word_cnt_d = '0;
        end else begin
          wr_en      = 1'b1;
          word_cnt_d = word_cnt_q + CntW'(1);
          if (item_i.last) begin
            word_idx_d   = '0;
            bit_idx_d    = '0;
            tick_d       = '0;
            burst_d      = 1'b0;
            start_done_d = 1'b0;
            sending_d    = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_ticks_q <= StartTicksRst;
      one_ticks_q   <= OneTicksRst;
      zero_ticks_q  <= ZeroTicksRst;
      pause_ticks_q <= PauseTicksRst;
      word_cnt_q    <= '0;
      word_idx_q    <= '0;
      bit_idx_q     <= '0;
      tick_q        <= '0;
      burst_q       <= 1'b0;
      start_done_q  <= 1'b0;
      sending_q     <= 1'b0;
      res_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgStartTicks: start_ticks_q <= cfg_wdata_i;
          CfgOneTicks:   one_ticks_q   <= cfg_wdata_i;
          CfgZeroTicks:  zero_ticks_q  <= cfg_wdata_i;
          CfgPauseTicks: pause_ticks_q <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
      word_cnt_q   <= word_cnt_d;
      word_idx_q   <= word_idx_d;
      bit_idx_q    <= bit_idx_d;
      tick_q       <= tick_d;
      burst_q      <= burst_d;
      start_done_q <= start_done_d;
      sending_q    <= sending_d;
      if (step) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q.carrier_on   <= sending_d & burst_d;
      res_q.driver_on    <= sending_d;
      res_q.busy_res     <= sending_d;
      res_q.load_refused <= refused;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[word_cnt_q[AddrW-1:0]] <= item_i.word;
    end
    rd_word_q <= store_q[rd_addr];
  end

`ifndef SYNTH
  a_burst_needs_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    burst_q |-> sending_q)
    else $error("burst phase outside a frame");
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sending_q |-> (word_idx_q == '0 && bit_idx_q == '0 && tick_q == '0 && !start_done_q))
    else $error("sequencer counters not cleared while idle");
  a_bit_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_idx_q <= LastBitIdx)
    else $error("bit index beyond word");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    word_cnt_q <= CntW'(MAX_WORDS) && word_idx_q <= word_cnt_q)
    else $error("word counters out of range");
`endif

endmodule

// ----- test/tb_pulse_burst_frame_transmitter.sv -----
`timescale 1ns / 1ps
// Testbench of pulse_burst_frame_transmitter: loads frames, runs timer ticks
// and compares every result transfer with a cycle-free model of the line.
// Depends on pbft_pkg and the RTL of the block.
module tb_pulse_burst_frame_transmitter;
  import pbft_pkg::*;

  localparam int unsigned RandomItems  = 1950;
  localparam int unsigned CycleLimit   = 500000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned IdlePct      = 29;
  localparam logic [TickW-1:0]   TickMax       = '1;
  localparam logic [CfgIdxW-1:0] FirstSpareIdx = CfgIdxW'(CfgPauseTicks + 1);

  localparam pbft_result_t LineIdle = '0;
  localparam pbft_result_t LineSending =
    '{carrier_on: 1'b0, driver_on: 1'b1, busy_res: 1'b1, load_refused: 1'b0};
  localparam pbft_result_t LineRefused =
    '{carrier_on: 1'b0, driver_on: 1'b1, busy_res: 1'b1, load_refused: 1'b1};

  typedef struct packed {
    cmd_e             cmd;
    logic [ByteW-1:0] data;
    logic             last;
    logic [5:0]       reps;
    logic             fixed_on;
    pbft_result_t     fixed;
  } script_row_t;

  // With all timing registers at zero, a one-byte frame ends on its twenty-first tick.
  script_row_t script [6] = '{
    '{CmdTick, 8'h00, 1'b0, 6'd1,  1'b1, LineIdle},
    '{CmdTick, 8'hFF, 1'b1, 6'd1,  1'b1, LineIdle},
    '{CmdLoad, 8'h80, 1'b1, 6'd1,  1'b1, LineSending},
    '{CmdLoad, 8'hFF, 1'b1, 6'd1,  1'b1, LineRefused},
    '{CmdTick, 8'h00, 1'b0, 6'd20, 1'b0, LineIdle},
    '{CmdTick, 8'h00, 1'b0, 6'd1,  1'b1, LineIdle}
  };

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [TickW-1:0]   cfg_wdata_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               command_i;
  logic [ByteW-1:0]   data_byte_i;
  logic               last_byte_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               carrier_on_o;
  logic               driver_on_o;
  logic               busy_res_o;
  logic               load_refused_o;

  logic [WordW-1:0] word_mem [MaxWords];
  int unsigned      words_held;
  int unsigned      bit_ptr;
  logic [TickW-1:0] ticks_left;
  logic             in_burst;
  logic             preamble_done;
  logic             tx_on;
  logic [TickW-1:0] start_len;
  logic [TickW-1:0] one_len;
  logic [TickW-1:0] zero_len;
  logic [TickW-1:0] pause_len;

  pbft_result_t expected_line [$];
  pbft_result_t want;
  bit           failed;
  bit           calm;
  int unsigned  frame_items;
  int unsigned  cycle_count = 0;

  pulse_burst_frame_transmitter dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .carrier_on_o   (carrier_on_o),
    .driver_on_o    (driver_on_o),
    .busy_res_o     (busy_res_o),
    .load_refused_o (load_refused_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= IdlePct);
  end

  function automatic pbft_result_t transmit_step(cmd_e cmd, logic [ByteW-1:0] data,
                                                 logic last);
    pbft_result_t line;
    logic         refused;
    refused = 1'b0;
    if (cmd == CmdTick) begin
      if (tx_on) begin
        if (ticks_left != 0) begin
          ticks_left = ticks_left - 1'b1;
        end else if (bit_ptr >= words_held * WordW || bit_ptr >= MaxWords * WordW) begin
          bit_ptr       = 0;
          ticks_left    = '0;
          preamble_done = 1'b0;
          in_burst      = 1'b0;
          tx_on         = 1'b0;
          words_held    = 0;
        end else if (in_burst) begin
          in_burst   = 1'b0;
          ticks_left = pause_len;
        end else begin
          if (!preamble_done) begin
            ticks_left    = start_len;
            preamble_done = 1'b1;
          end else begin
            ticks_left = word_mem[bit_ptr / WordW][bit_ptr % WordW] ? one_len : zero_len;
            bit_ptr++;
          end
          in_burst = 1'b1;
        end
      end
    end else if (tx_on) begin
      refused = 1'b1;
    end else if (words_held >= MaxWords) begin
      // A full store drops the partial frame so that loading can start over.
      words_held = 0;
      refused    = 1'b1;
    end else begin
      word_mem[words_held] = {^data, data};
      words_held++;
      if (last) begin
        bit_ptr       = 0;
        ticks_left    = '0;
        in_burst      = 1'b0;
        preamble_done = 1'b0;
        tx_on         = 1'b1;
      end
    end
    line.carrier_on   = tx_on && in_burst;
    line.driver_on    = tx_on;
    line.busy_res     = tx_on;
    line.load_refused = refused;
    return line;
  endfunction

  function automatic logic [TickW-1:0] pick_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) begin
      return TickW'($urandom_range(1));
    end else if (r < 90) begin
      return TickW'($urandom_range(3, 2));
    end
    return TickW'($urandom_range(7, 4));
  endfunction

  task automatic check_bit(input string name, input logic exp_bit, input logic got_bit);
    if (got_bit !== exp_bit) begin
      $display("%0t: %s expected %b, got %b", $time, name, exp_bit, got_bit);
      failed = 1'b1;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_line.size() == 0) begin
        $display("%0t: unexpected result transfer, expected none, got %b%b%b%b", $time,
                 carrier_on_o, driver_on_o, busy_res_o, load_refused_o);
        failed = 1'b1;
      end else begin
        want = expected_line.pop_front();
        check_bit("carrier_on", want.carrier_on, carrier_on_o);
        check_bit("driver_on", want.driver_on, driver_on_o);
        check_bit("busy_res", want.busy_res, busy_res_o);
        check_bit("load_refused", want.load_refused, load_refused_o);
      end
    end
  end

  task automatic send_item(input cmd_e cmd, input logic [ByteW-1:0] data, input logic last,
                           input logic fixed_on, input pbft_result_t fixed);
    pbft_result_t line;
    while (!calm && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    command_i   <= cmd;
    data_byte_i <= data;
    last_byte_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    line = transmit_step(cmd, data, last);
    expected_line.push_back(fixed_on ? fixed : line);
    frame_items++;
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (expected_line.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [TickW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    case (idx)
      CfgStartTicks: start_len = value;
      CfgOneTicks:   one_len   = value;
      CfgZeroTicks:  zero_len  = value;
      CfgPauseTicks: pause_len = value;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic program_timing(input logic [TickW-1:0] s, input logic [TickW-1:0] o,
                                input logic [TickW-1:0] z, input logic [TickW-1:0] p,
                                input logic spare);
    write_reg(CfgStartTicks, s);
    if (spare) begin
      write_reg(CfgIdxW'($urandom_range(2 ** CfgIdxW - 1, FirstSpareIdx)),
                TickW'($urandom_range(TickMax)));
    end
    write_reg(CfgOneTicks, o);
    write_reg(CfgZeroTicks, z);
    write_reg(CfgPauseTicks, p);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic load_frame(input int unsigned n, input logic close);
    for (int unsigned i = 0; i < n; i++) begin
      if (!calm && $urandom_range(99) < 10) begin
        send_item(CmdTick, ByteW'($urandom_range(255)), 1'($urandom_range(1)), 1'b0,
                  LineIdle);
      end
      send_item(CmdLoad, ByteW'($urandom_range(255)), close && (i == n - 1), 1'b0,
                LineIdle);
    end
  endtask

  task automatic run_frame();
    while (tx_on) begin
      if (!calm && $urandom_range(999) < 8) begin
        drain_results();
      end
      if (!calm && $urandom_range(99) < 8) begin
        send_item(CmdLoad, ByteW'($urandom_range(255)), 1'($urandom_range(1)), 1'b0,
                  LineIdle);
      end else begin
        send_item(CmdTick, ByteW'($urandom_range(255)), 1'($urandom_range(1)), 1'b0,
                  LineIdle);
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CfgStartTicks;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    command_i     = CmdLoad;
    data_byte_i   = '0;
    last_byte_i   = 1'b0;
    out_ready_i   = 1'b0;
    failed        = 1'b0;
    calm          = 1'b0;
    frame_items   = 0;
    words_held    = 0;
    bit_ptr       = 0;
    ticks_left    = '0;
    in_burst      = 1'b0;
    preamble_done = 1'b0;
    tx_on         = 1'b0;
    start_len     = StartTicksRst;
    one_len       = OneTicksRst;
    zero_len      = ZeroTicksRst;
    pause_len     = PauseTicksRst;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    program_timing('0, '0, '0, '0, 1'b1);
    foreach (script[i]) begin
      repeat (script[i].reps) begin
        send_item(script[i].cmd, script[i].data, script[i].last, script[i].fixed_on,
                  script[i].fixed);
      end
    end
    drain_results();

    // A frame that fills the whole store, sent with no idling on either side.
    calm = 1'b1;
    load_frame(MaxWords, 1'b1);
    run_frame();
    calm = 1'b0;
    drain_results();

    program_timing(TickMax, '0, '0, '0, 1'b0);
    load_frame(1, 1'b1);
    run_frame();

    while (frame_items < RandomItems) begin
      drain_results();
      calm = ($urandom_range(9) == 0);
      program_timing(pick_len(), pick_len(), pick_len(), pick_len(), $urandom_range(3) == 0);
      if ($urandom_range(99) < 30) begin
        repeat ($urandom_range(3, 1)) begin
          send_item(CmdTick, ByteW'($urandom_range(255)), 1'($urandom_range(1)), 1'b0,
                    LineIdle);
        end
      end
      if ($urandom_range(99) < 8) begin
        load_frame(MaxWords, 1'b0);
        send_item(CmdLoad, ByteW'($urandom_range(255)), 1'($urandom_range(1)), 1'b0,
                  LineIdle);
      end
      load_frame($urandom_range(3, 1), 1'b1);
      run_frame();
    end
    calm = 1'b0;
    drain_results();

    if (!failed) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
